@@ rtl/core/cfr_pkg.sv @@
// Package for the command frame receiver: codes, constants and the beat
// and result structures shared by the parser and the top level.
// No dependencies.
`default_nettype none

package cfr_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd34;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd105;

  localparam logic [7:0] MIN_LEN    = 8'h06;
  localparam logic [8:0] FIRST_DATA = 9'h009;
  localparam logic [8:0] LEN_OFFSET = 9'h003;

  // word index of each register (paddr[2])
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_DONE    = 3'd3,
    EV_DROPPED = 3'd4,
    EV_CLEARED = 3'd5
  } evt_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } beat_t;

  typedef struct packed {
    evt_t        event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_pos;
    logic        frame_ready;
    logic [7:0]  frame_len;
    logic [15:0] hardware_id;
    logic [15:0] message_id;
    logic [7:0]  destination;
    logic [7:0]  command;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/cfr_parser.sv @@
// Frame parser: phase state machine, header registers and result register.
// Depends on cfr_pkg.
`default_nettype none

module cfr_parser
  import cfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  beat_valid,
  input  wire beat_t beat,
  output logic       beat_take,
  output logic       res_valid,
  input  wire logic  res_stall,
  output res_t       res
);

  typedef enum logic [3:0] {
    PH_SYNC0  = 4'd0,
    PH_SYNC1  = 4'd1,
    PH_LEN    = 4'd2,
    PH_HW_LO  = 4'd3,
    PH_HW_HI  = 4'd4,
    PH_MSG_LO = 4'd5,
    PH_MSG_HI = 4'd6,
    PH_DEST   = 4'd7,
    PH_CMD    = 4'd8,
    PH_DATA   = 4'd9,
    PH_DONE   = 4'd10
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] hw_r, hw_nxt;
  logic [15:0] msg_r, msg_nxt;
  logic [7:0]  dest_r, dest_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        res_valid_r;
  res_t        res_r, res_nxt;
  evt_t        ev;
  logic [7:0]  pbyte;
  logic [7:0]  ppos;
  logic [8:0]  end_pos;
  logic        last_data;
  logic        has_data;

  assign beat_take = beat_valid & (~res_valid_r | ~res_stall);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign end_pos   = {1'b0, len_r} + LEN_OFFSET;
  // write position after this payload byte reaches the end
  assign last_data = ({1'b0, pos_r} + FIRST_DATA + 9'd1) >= end_pos;
  assign has_data  = FIRST_DATA < end_pos;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    hw_nxt    = hw_r;
    msg_nxt   = msg_r;
    dest_nxt  = dest_r;
    cmd_nxt   = cmd_r;
    ev        = EV_IGNORED;
    pbyte     = 8'd0;
    ppos      = 8'd0;
    if (beat.opcode == OP_RELEASE) begin
      phase_nxt = PH_SYNC0;
      pos_nxt   = 8'd0;
      ev        = EV_CLEARED;
    end else begin
      unique case (phase_r)
        PH_SYNC0: begin
          if (beat.rx_byte == cfg.sync_first) begin
            phase_nxt = PH_SYNC1;
            ev        = EV_HEADER;
          end
        end
        PH_SYNC1: begin
          if (beat.rx_byte == cfg.sync_second) begin
            phase_nxt = PH_LEN;
            ev        = EV_HEADER;
          end else begin
            phase_nxt = PH_SYNC0;
            ev        = EV_DROPPED;
          end
        end
        PH_LEN: begin
          if (beat.rx_byte >= MIN_LEN) begin
            len_nxt   = beat.rx_byte;
            pos_nxt   = 8'd0;
            phase_nxt = PH_HW_LO;
            ev        = EV_HEADER;
          end else begin
            phase_nxt = PH_SYNC0;
            ev        = EV_DROPPED;
          end
        end
        PH_HW_LO: begin
          hw_nxt    = {8'd0, beat.rx_byte};
          phase_nxt = PH_HW_HI;
          ev        = EV_HEADER;
        end
        PH_HW_HI: begin
          hw_nxt    = {beat.rx_byte, hw_r[7:0]};
          phase_nxt = PH_MSG_LO;
          ev        = EV_HEADER;
        end
        PH_MSG_LO: begin
          msg_nxt   = {8'd0, beat.rx_byte};
          phase_nxt = PH_MSG_HI;
          ev        = EV_HEADER;
        end
        PH_MSG_HI: begin
          msg_nxt   = {beat.rx_byte, msg_r[7:0]};
          phase_nxt = PH_DEST;
          ev        = EV_HEADER;
        end
        PH_DEST: begin
          dest_nxt  = beat.rx_byte;
          phase_nxt = PH_CMD;
          ev        = EV_HEADER;
        end
        PH_CMD: begin
          cmd_nxt = beat.rx_byte;
          if (has_data) begin
            phase_nxt = PH_DATA;
            ev        = EV_HEADER;
          end else begin
            phase_nxt = PH_DONE;
            ev        = EV_DONE;
          end
        end
        PH_DATA: begin
          pbyte   = beat.rx_byte;
          ppos    = pos_r;
          pos_nxt = pos_r + 8'd1;
          if (last_data) begin
            phase_nxt = PH_DONE;
            ev        = EV_DONE;
          end else begin
            ev = EV_PAYLOAD;
          end
        end
        PH_DONE: begin
          ev = EV_IGNORED;
        end
        default: begin
          phase_nxt = PH_SYNC0;
        end
      endcase
    end

    res_nxt              = '0;
    res_nxt.event_res    = ev;
    res_nxt.payload_byte = pbyte;
    res_nxt.payload_pos  = ppos;
    if (phase_nxt == PH_DONE) begin
      res_nxt.frame_ready = 1'b1;
      res_nxt.frame_len   = len_nxt;
      res_nxt.hardware_id = hw_nxt;
      res_nxt.message_id  = msg_nxt;
      res_nxt.destination = dest_nxt;
      res_nxt.command     = cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC0;
      pos_r       <= 8'd0;
      res_valid_r <= 1'b0;
    end else begin
      if (beat_take) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        res_valid_r <= 1'b1;
      end else if (!res_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take) begin
      len_r  <= len_nxt;
      hw_r   <= hw_nxt;
      msg_r  <= msg_nxt;
      dest_r <= dest_nxt;
      cmd_r  <= cmd_nxt;
      res_r  <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/command_frame_receiver.sv @@
// Command frame receiver top level: APB register file, input beat register
// and the frame parser. Depends on cfr_pkg and cfr_parser.
//
//   port group | dir | handshake          | content
//   in_*       | in  | in_valid/in_stall  | opcode, rx_byte
//   out_*      | out | out_valid/out_stall| event and held frame header
//   p*         | in  | psel/penable       | sync_first (0x0), sync_second (0x4)
//
// One beat per cycle sustained while out_stall is low; a beat's result reaches out_*
// through the input register, then the parser and its result register.
// The input register lets a beat be taken while a result waits to be taken.
// Synchronous active-low reset returns the parser to hunting for sync.
// out_stall holds the result and, once the input register is full, raises in_stall.
`default_nettype none

module command_frame_receiver
  import cfr_pkg::*;
#(
  parameter int unsigned ADDR_W = CFG_ADDR_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [7:0]            in_rx_byte,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_event_res,
  output logic [7:0]                 out_payload_byte,
  output logic [7:0]                 out_payload_pos,
  output logic                       out_frame_ready,
  output logic [7:0]                 out_frame_len,
  output logic [15:0]                out_hardware_id,
  output logic [15:0]                out_message_id,
  output logic [7:0]                 out_destination,
  output logic [7:0]                 out_command,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cfg_t  cfg_r;
  beat_t beat_r;
  logic  beat_valid_r;
  logic  beat_take;
  logic  wr_en;
  res_t  res;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_SYNC_FIRST) begin
        cfg_r.sync_first <= pwdata[7:0];
      end else begin
        cfg_r.sync_second <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SYNC_FIRST) begin
      prdata[7:0] = cfg_r.sync_first;
    end else begin
      prdata[7:0] = cfg_r.sync_second;
    end
  end

  assign in_stall = beat_valid_r & ~beat_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      beat_valid_r <= 1'b1;
    end else if (beat_take) begin
      beat_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat_r.opcode  <= in_opcode;
      beat_r.rx_byte <= in_rx_byte;
    end
  end

  cfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .beat_valid (beat_valid_r),
    .beat       (beat_r),
    .beat_take  (beat_take),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign out_event_res    = res.event_res;
  assign out_payload_byte = res.payload_byte;
  assign out_payload_pos  = res.payload_pos;
  assign out_frame_ready  = res.frame_ready;
  assign out_frame_len    = res.frame_len;
  assign out_hardware_id  = res.hardware_id;
  assign out_message_id   = res.message_id;
  assign out_destination  = res.destination;
  assign out_command      = res.command;

endmodule

`default_nettype wire

@@ rtl/core/cfr_checker.sv @@
// Port-level checks for command_frame_receiver, bound to the top level.
// Depends on cfr_pkg.
`default_nettype none

module cfr_checker
  import cfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_event_res,
  input wire logic [7:0]  out_payload_pos,
  input wire logic        out_frame_ready
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_payload_pos))
    else $error("stalled result beat changed");

  a_ready_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_CLEARED || out_event_res == EV_DROPPED
      || out_event_res == EV_PAYLOAD || out_event_res == EV_HEADER)
      |-> !out_frame_ready)
    else $error("frame held on non-completing event");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_DONE |-> out_frame_ready)
    else $error("completion without held frame");

  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_pos != 8'd0
      |-> (out_event_res == EV_PAYLOAD || out_event_res == EV_DONE))
    else $error("payload position outside payload beat");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_res   (out_event_res),
  .out_payload_pos (out_payload_pos),
  .out_frame_ready (out_frame_ready)
);

`default_nettype wire

@@ bench/command_frame_receiver_tb.sv @@
// Self-checking bench for command_frame_receiver: random byte and release
// beats under several sync settings, checked against an in-bench frame decoder.
// Depends on cfr_pkg and the command_frame_receiver RTL.
`timescale 1ns / 100ps

module command_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned BEATS_PER_SETTING = 270;

  typedef enum logic [3:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_LEN, TAKE_HW_LO, TAKE_HW_HI, TAKE_MSG_LO,
    TAKE_MSG_HI, TAKE_DEST, TAKE_CMD, TAKE_DATA, FRAME_HELD
  } frame_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_pos;
  logic        out_frame_ready;
  logic [7:0]  out_frame_len;
  logic [15:0] out_hardware_id;
  logic [15:0] out_message_id;
  logic [7:0]  out_destination;
  logic [7:0]  out_command;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  command_frame_receiver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_res(out_event_res), .out_payload_byte(out_payload_byte),
    .out_payload_pos(out_payload_pos), .out_frame_ready(out_frame_ready),
    .out_frame_len(out_frame_len), .out_hardware_id(out_hardware_id),
    .out_message_id(out_message_id), .out_destination(out_destination),
    .out_command(out_command),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder copy of the block
  logic [7:0]   sync_first_q = SYNC_FIRST_RST;
  logic [7:0]   sync_second_q = SYNC_SECOND_RST;
  frame_phase_t ph = HUNT_FIRST;
  logic [8:0]   wr_pos = '0;
  logic [8:0]   end_pos = '0;
  logic [7:0]   len_q = '0;
  logic [15:0]  hw_q = '0;
  logic [15:0]  msg_q = '0;
  logic [7:0]   dest_q = '0;
  logic [7:0]   cmd_q = '0;

  beat_t stream_beats[$];
  res_t  awaited_results[$];
  int    n_pushed = 0;
  int    n_checked = 0;
  int    n_errors = 0;
  int    ev_count[0:7];
  int    cycles = 0;
  int    gap_left = 0;
  int    stall_left = 0;
  bit    in_burst = 1'b0;
  bit    out_burst = 1'b0;

  function automatic void restart_hunt();
    ph = HUNT_FIRST;
    wr_pos = '0;
    end_pos = '0;
    len_q = '0;
    hw_q = '0;
    msg_q = '0;
    dest_q = '0;
    cmd_q = '0;
  endfunction

  function automatic res_t deframe_beat(input logic op, input logic [7:0] rx);
    res_t       r;
    logic [8:0] offs;
    r = '0;
    r.event_res = EV_IGNORED;
    if (op == OP_RELEASE) begin
      restart_hunt();
      r.event_res = EV_CLEARED;
    end else begin
      case (ph)
        HUNT_FIRST: begin
          if (rx == sync_first_q) begin
            ph = HUNT_SECOND;
            r.event_res = EV_HEADER;
          end
        end
        HUNT_SECOND: begin
          if (rx == sync_second_q) begin
            ph = TAKE_LEN;
            r.event_res = EV_HEADER;
          end else begin
            restart_hunt();
            r.event_res = EV_DROPPED;
          end
        end
        TAKE_LEN: begin
          if (rx >= MIN_LEN) begin
            len_q = rx;
            wr_pos = FIRST_DATA;
            end_pos = {1'b0, rx} + LEN_OFFSET;
            ph = TAKE_HW_LO;
            r.event_res = EV_HEADER;
          end else begin
            restart_hunt();
            r.event_res = EV_DROPPED;
          end
        end
        TAKE_HW_LO: begin
          hw_q = {8'h00, rx};
          ph = TAKE_HW_HI;
          r.event_res = EV_HEADER;
        end
        TAKE_HW_HI: begin
          hw_q[15:8] = rx;
          ph = TAKE_MSG_LO;
          r.event_res = EV_HEADER;
        end
        TAKE_MSG_LO: begin
          msg_q = {8'h00, rx};
          ph = TAKE_MSG_HI;
          r.event_res = EV_HEADER;
        end
        TAKE_MSG_HI: begin
          msg_q[15:8] = rx;
          ph = TAKE_DEST;
          r.event_res = EV_HEADER;
        end
        TAKE_DEST: begin
          dest_q = rx;
          ph = TAKE_CMD;
          r.event_res = EV_HEADER;
        end
        TAKE_CMD: begin
          cmd_q = rx;
          if (wr_pos < end_pos) begin
            ph = TAKE_DATA;
            r.event_res = EV_HEADER;
          end else begin
            ph = FRAME_HELD;
            r.event_res = EV_DONE;
          end
        end
        TAKE_DATA: begin
          if (wr_pos < end_pos) begin
            offs = wr_pos - FIRST_DATA;
            r.payload_byte = rx;
            r.payload_pos = offs[7:0];
            wr_pos = wr_pos + 9'd1;
            r.event_res = EV_PAYLOAD;
          end
          if (wr_pos >= end_pos) begin
            ph = FRAME_HELD;
            r.event_res = EV_DONE;
          end
        end
        default: ;
      endcase
    end
    if (ph == FRAME_HELD) begin
      r.frame_ready = 1'b1;
      r.frame_len = len_q;
      r.hardware_id = hw_q;
      r.message_id = msg_q;
      r.destination = dest_q;
      r.command = cmd_q;
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
      n_errors++;
    end
  endtask

  // driver: one beat per handshake, random gap between beats (none in a burst)
  always @(posedge clk) begin : drv
    logic  busy;
    beat_t nb;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        awaited_results.push_back(deframe_beat(in_opcode, in_rx_byte));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_beats.size() > 0) begin
          nb = stream_beats.pop_front();
          in_opcode <= nb.opcode;
          in_rx_byte <= nb.rx_byte;
          busy = 1'b1;
          gap_left = in_burst ? 0 : $urandom_range(0, 9);
          if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        end
      end
      in_valid <= busy;
    end
  end

  // monitor: compare each result beat with the oldest awaited one
  always @(posedge clk) begin : mon
    res_t er;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result beat: event_res %0d", out_event_res);
          n_errors++;
        end else begin
          er = awaited_results.pop_front();
          check_field("event_res", er.event_res, out_event_res);
          check_field("payload_byte", er.payload_byte, out_payload_byte);
          check_field("payload_pos", er.payload_pos, out_payload_pos);
          check_field("frame_ready", er.frame_ready, out_frame_ready);
          check_field("frame_len", er.frame_len, out_frame_len);
          check_field("hardware_id", er.hardware_id, out_hardware_id);
          check_field("message_id", er.message_id, out_message_id);
          check_field("destination", er.destination, out_destination);
          check_field("command", er.command, out_command);
          ev_count[er.event_res]++;
          n_checked++;
        end
        stall_left = out_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_beat(input logic op, input logic [7:0] rx);
    beat_t nb;
    nb.opcode = op;
    nb.rx_byte = rx;
    stream_beats.push_back(nb);
    n_pushed++;
  endtask

  task automatic wait_idle();
    while (n_checked != n_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic idx, input logic [7:0] wdata,
                          output logic [7:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= CFG_DATA_W'(wdata);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    logic [7:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    if (idx == REG_SYNC_FIRST) sync_first_q = value;
    else sync_second_q = value;
    apb_xfer(1'b0, idx, 8'h00, rd);
    if (rd !== value) begin
      $error("prdata: expected 0x%0h, got 0x%0h", value, rd);
      n_errors++;
    end
  endtask

  // mostly whole frames with random content; some noise, drops and cut frames
  task automatic queue_frames(input int target);
    int         start, noise, kind, len, keep;
    logic [7:0] nb;
    logic [7:0] body[$];
    start = n_pushed;
    noise = 0;
    while (n_pushed - start - noise < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(1, 4)) begin
          nb = 8'($urandom);
          if (nb == sync_first_q) nb = ~nb;
          queue_beat(($urandom_range(0, 3) == 0) ? OP_RELEASE : OP_BYTE, nb);
          noise++;
        end
      end else if (kind == 2) begin
        nb = 8'($urandom);
        if (nb == sync_second_q) nb = ~nb;
        queue_beat(OP_BYTE, sync_first_q);
        queue_beat(OP_BYTE, nb);
      end else if (kind == 3) begin
        queue_beat(OP_BYTE, sync_first_q);
        queue_beat(OP_BYTE, sync_second_q);
        queue_beat(OP_BYTE, 8'($urandom_range(0, 5)));
      end else begin
        case ($urandom_range(0, 49))
          0: len = 255;
          1: len = 6;
          default: len = 6 + $urandom_range(0, 24);
        endcase
        body.delete();
        body.push_back(len[7:0]);
        repeat (len) body.push_back(8'($urandom));
        keep = (kind < 6) ? $urandom_range(1, len) : body.size();
        queue_beat(OP_BYTE, sync_first_q);
        queue_beat(OP_BYTE, sync_second_q);
        for (int k = 0; k < keep; k++) queue_beat(OP_BYTE, body[k]);
        if (kind >= 6) repeat ($urandom_range(0, 2)) queue_beat(OP_BYTE, 8'($urandom));
        queue_beat(OP_RELEASE, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] frame6[9];
    logic [7:0] syncs[8];
    frame6 = '{SYNC_FIRST_RST, SYNC_SECOND_RST, MIN_LEN, 8'h00, 8'hFF,
               8'hFF, 8'h00, 8'hAA, 8'h55};
    syncs = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'h5A, 8'h00, 8'h00};
    foreach (ev_count[k]) ev_count[k] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset sync values; minimum-length frame ends on its command byte
    queue_beat(OP_BYTE, 8'h00);
    foreach (frame6[k]) queue_beat(OP_BYTE, frame6[k]);
    queue_beat(OP_BYTE, 8'hFF);
    queue_beat(OP_RELEASE, 8'h00);
    queue_beat(OP_BYTE, SYNC_FIRST_RST);
    queue_beat(OP_BYTE, SYNC_FIRST_RST);
    queue_beat(OP_BYTE, SYNC_FIRST_RST);
    queue_beat(OP_BYTE, SYNC_SECOND_RST);
    queue_beat(OP_BYTE, MIN_LEN - 8'd1);
    queue_beat(OP_RELEASE, 8'hFF);
    queue_beat(OP_BYTE, SYNC_FIRST_RST);
    queue_beat(OP_RELEASE, 8'h5A);
    queue_frames(BEATS_PER_SETTING);
    wait_idle();

    syncs[6] = 8'($urandom);
    syncs[7] = 8'($urandom);
    for (int s = 0; s < 4; s++) begin
      cfg_write(REG_SYNC_FIRST, syncs[2 * s]);
      cfg_write(REG_SYNC_SECOND, syncs[2 * s + 1]);
      queue_frames(BEATS_PER_SETTING);
      wait_idle();
    end

    $display("%0d beats checked over 5 sync settings: %0d frames complete, %0d payload",
             n_checked, ev_count[EV_DONE], ev_count[EV_PAYLOAD]);
    $display("beats, %0d drops, %0d releases, %0d ignored beats",
             ev_count[EV_DROPPED], ev_count[EV_CLEARED], ev_count[EV_IGNORED]);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/cfr_pkg.sv
rtl/core/cfr_parser.sv
rtl/core/command_frame_receiver.sv
rtl/core/cfr_checker.sv
bench/command_frame_receiver_tb.sv
